@@ rtl/gic_pkg.sv @@
// ----------------------------------------------------------------------------
// gic_pkg
// types, opcodes and controller/datapath command set for the gaussian
// integer calculator
// ----------------------------------------------------------------------------
package gic_pkg;

  // opcodes of an input transaction
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_REPEAT = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;

  // saved operator code meaning nothing saved
  localparam logic [2:0] SAVED_NONE = 3'd0;

  // operand function codes
  localparam logic [1:0] FN_NONE   = 2'd0;
  localparam logic [1:0] FN_SQUARE = 2'd1;
  localparam logic [1:0] FN_RECIP  = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic [1:0]         func;
    logic signed [31:0] operand_re;
    logic signed [31:0] operand_im;
    logic               last;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic               error;
  } out_data_t;

  // multiplier operand sources
  typedef enum logic [1:0] {
    SRC_C      = 2'd0,
    SRC_D      = 2'd1,
    SRC_ACC_RE = 2'd2,
    SRC_ACC_IM = 2'd3
  } src_e;

  // divider numerator sources
  typedef enum logic [1:0] {
    NUM_C    = 2'd0,
    NUM_NEGY = 2'd1,
    NUM_P0   = 2'd2,
    NUM_P1   = 2'd3
  } num_e;

  // divider quotient destinations
  typedef enum logic [1:0] {
    DST_X      = 2'd0,
    DST_Y      = 2'd1,
    DST_ACC_RE = 2'd2,
    DST_ACC_IM = 2'd3
  } dst_e;

  typedef struct packed {
    logic       capture;
    logic       err_clr;
    logic       err_set;
    logic       clear_all;
    logic       use_saved;
    logic       mul_en;
    src_e       mul_a;
    src_e       mul_b;
    logic [1:0] mul_dst;
    logic       sq_wb;
    logic       norm_wb;
    logic       num_wb;
    logic       recip_zero;
    logic       div_start;
    num_e       div_num;
    logic       div_wb;
    dst_e       div_dst;
    logic       acc_load;
    logic       acc_add;
    logic       acc_sub;
    logic       acc_mul_wb;
    logic       save;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_zero;
    logic div_busy;
  } dp_sts_t;

endpackage

@@ rtl/gaussian_integer_calculator_unit.sv @@
// ----------------------------------------------------------------------------
// gaussian_integer_calculator_unit
// complex integer calculator with accumulator, repeat and error flag
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i / in_stall_o carries one transaction per step of
//   an expression (op, func, operand, last); output channel out_valid_o /
//   out_stall_i carries one result per transaction marked last
//   one transaction is worked on at a time; the unit stalls its input until
//   the transaction's sequence is done
//   the sequences use the single shared multiplier (one product a cycle) and,
//   for a divide or reciprocal, the bit-serial divider (two quotients each);
//   a zero divisor skips the divider and flags an error
//   a result sits in an output register; the next transaction is accepted
//   while it waits, and only a further result waits for the slot to free
//   reset clears accumulator, saved operator/operand and error flag and
//   drops any pending result
// ----------------------------------------------------------------------------
module gaussian_integer_calculator_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gic_pkg::in_data_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gic_pkg::out_data_t out_data_o
);

  import gic_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns op decode, saved operator code and output valid
  gic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_op_i     (in_data_i.op),
    .in_func_i   (in_data_i.func),
    .in_last_i   (in_data_i.last),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: DATA_WIDTH wrapping arithmetic, result is the low 32 bits
  gic_dp #(.DW(DATA_WIDTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

@@ rtl/gic_div.sv @@
// ----------------------------------------------------------------------------
// gic_div
// radix-2 restoring signed divider, truncating toward zero, one bit a cycle
// ----------------------------------------------------------------------------
module gic_div #(
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [DW-1:0] quo_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic          neg_q, neg_d;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      rem_d  = '0;
      quo_d  = num_i[DW-1] ? (~num_i + 1'b1) : num_i;
      den_d  = den_i[DW-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[DW-1] ^ den_i[DW-1];
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

@@ rtl/gic_dp.sv @@
// ----------------------------------------------------------------------------
// gic_dp
// datapath: operand, accumulator, saved operand, products, norm, shared
// multiplier and divider, output payload register
// ----------------------------------------------------------------------------
module gic_dp #(
  parameter int DW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gic_pkg::in_data_t  in_data_i,
  input  gic_pkg::dp_cmd_t   cmd_i,
  output gic_pkg::dp_sts_t   sts_o,
  output gic_pkg::out_data_t out_data_o
);

  import gic_pkg::*;

  localparam int LW = (DW < 32) ? DW : 32;

  logic [DW-1:0] x_q, x_d, y_q, y_d;
  logic [DW-1:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [DW-1:0] sav_re_q, sav_re_d, sav_im_q, sav_im_d;
  logic          err_q, err_d;
  logic [DW-1:0] p_q [4];
  logic [DW-1:0] p_d [4];
  logic [DW-1:0] n_q, n_d;
  out_data_t     out_q, out_d;

  logic [DW-1:0] c_op, d_op, mul_a, mul_b, prod;
  logic [DW-1:0] div_num, div_quo;
  logic          div_busy;

  assign c_op = cmd_i.use_saved ? sav_re_q : x_q;
  assign d_op = cmd_i.use_saved ? sav_im_q : y_q;

  function automatic logic [DW-1:0] pick(src_e s, logic [DW-1:0] c, logic [DW-1:0] d,
                                         logic [DW-1:0] ar, logic [DW-1:0] ai);
    logic [DW-1:0] r;
    case (s)
      SRC_C:      r = c;
      SRC_D:      r = d;
      SRC_ACC_RE: r = ar;
      default:    r = ai;
    endcase
    return r;
  endfunction

  assign mul_a = pick(cmd_i.mul_a, c_op, d_op, acc_re_q, acc_im_q);
  assign mul_b = pick(cmd_i.mul_b, c_op, d_op, acc_re_q, acc_im_q);
  assign prod  = mul_a * mul_b;

  always_comb begin
    case (cmd_i.div_num)
      NUM_C:    div_num = x_q;
      NUM_NEGY: div_num = ~y_q + 1'b1;
      NUM_P0:   div_num = p_q[0];
      default:  div_num = p_q[1];
    endcase
  end

  gic_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (n_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    sav_re_d = sav_re_q;
    sav_im_d = sav_im_q;
    err_d    = err_q;
    p_d      = p_q;
    n_d      = n_q;
    out_d    = out_q;

    if (cmd_i.capture) begin
      x_d = DW'(in_data_i.operand_re);
      y_d = DW'(in_data_i.operand_im);
    end
    if (cmd_i.err_clr) err_d = 1'b0;
    if (cmd_i.err_set) err_d = 1'b1;
    if (cmd_i.mul_en) p_d[cmd_i.mul_dst] = prod;
    if (cmd_i.sq_wb) begin
      x_d = p_q[0] - p_q[1];
      y_d = p_q[2] << 1;
    end
    if (cmd_i.norm_wb) n_d = p_q[0] + p_q[1];
    if (cmd_i.num_wb) begin
      p_d[0] = p_q[0] + p_q[1];
      p_d[1] = p_q[2] - p_q[3];
    end
    if (cmd_i.recip_zero) begin
      x_d = '0;
      y_d = '0;
    end
    if (cmd_i.div_wb) begin
      case (cmd_i.div_dst)
        DST_X:      x_d      = div_quo;
        DST_Y:      y_d      = div_quo;
        DST_ACC_RE: acc_re_d = div_quo;
        default:    acc_im_d = div_quo;
      endcase
    end
    if (cmd_i.acc_load) begin
      acc_re_d = x_q;
      acc_im_d = y_q;
    end
    if (cmd_i.acc_add) begin
      acc_re_d = acc_re_q + c_op;
      acc_im_d = acc_im_q + d_op;
    end
    if (cmd_i.acc_sub) begin
      acc_re_d = acc_re_q - c_op;
      acc_im_d = acc_im_q - d_op;
    end
    if (cmd_i.acc_mul_wb) begin
      acc_re_d = p_q[0] - p_q[1];
      acc_im_d = p_q[2] + p_q[3];
    end
    if (cmd_i.save) begin
      sav_re_d = x_q;
      sav_im_d = y_q;
    end
    if (cmd_i.clear_all) begin
      acc_re_d = '0;
      acc_im_d = '0;
      sav_re_d = '0;
      sav_im_d = '0;
      err_d    = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_d.result_re = 32'(acc_re_q[LW-1:0]);
      out_d.result_im = 32'(acc_im_q[LW-1:0]);
      out_d.error     = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
      sav_re_q <= '0;
      sav_im_q <= '0;
      err_q    <= 1'b0;
    end else begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
      sav_re_q <= sav_re_d;
      sav_im_q <= sav_im_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    p_q   <= p_d;
    n_q   <= n_d;
    out_q <= out_d;
  end

  assign sts_o.norm_zero = (n_q == '0);
  assign sts_o.div_busy  = div_busy;
  assign out_data_o      = out_q;

endmodule

@@ rtl/gic_ctrl.sv @@
// ----------------------------------------------------------------------------
// gic_ctrl
// sequencer: walks each transaction through function, operator and result
// steps and drives the datapath commands
// ----------------------------------------------------------------------------
module gic_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       in_op_i,
  input  logic [1:0]       in_func_i,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gic_pkg::dp_cmd_t cmd_o,
  input  gic_pkg::dp_sts_t sts_i
);

  import gic_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_F_M0   = 5'd1;
  localparam logic [4:0] ST_F_M1   = 5'd2;
  localparam logic [4:0] ST_F_M2   = 5'd3;
  localparam logic [4:0] ST_F_SQ   = 5'd4;
  localparam logic [4:0] ST_F_NORM = 5'd5;
  localparam logic [4:0] ST_F_CHK  = 5'd6;
  localparam logic [4:0] ST_F_DX   = 5'd7;
  localparam logic [4:0] ST_F_DY   = 5'd8;
  localparam logic [4:0] ST_OP     = 5'd9;
  localparam logic [4:0] ST_APPLY  = 5'd10;
  localparam logic [4:0] ST_M_M0   = 5'd11;
  localparam logic [4:0] ST_M_M1   = 5'd12;
  localparam logic [4:0] ST_M_M2   = 5'd13;
  localparam logic [4:0] ST_M_M3   = 5'd14;
  localparam logic [4:0] ST_M_WB   = 5'd15;
  localparam logic [4:0] ST_D_M0   = 5'd16;
  localparam logic [4:0] ST_D_M1   = 5'd17;
  localparam logic [4:0] ST_D_NORM = 5'd18;
  localparam logic [4:0] ST_D_CHK  = 5'd19;
  localparam logic [4:0] ST_D_P1   = 5'd20;
  localparam logic [4:0] ST_D_P2   = 5'd21;
  localparam logic [4:0] ST_D_P3   = 5'd22;
  localparam logic [4:0] ST_D_NUM  = 5'd23;
  localparam logic [4:0] ST_D_DS   = 5'd24;
  localparam logic [4:0] ST_D_WR   = 5'd25;
  localparam logic [4:0] ST_D_WI   = 5'd26;
  localparam logic [4:0] ST_FIN    = 5'd27;

  logic [4:0] state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [1:0] func_q, func_d;
  logic       last_q, last_d;
  logic [2:0] saved_op_q, saved_op_d;
  logic [2:0] eff_q, eff_d;
  logic       use_saved_q, use_saved_d;
  logic       out_valid_q, out_valid_d;
  dp_cmd_t    cmd;

  function automatic dp_cmd_t mul(dp_cmd_t c, src_e a, src_e b, logic [1:0] dst);
    dp_cmd_t r;
    r         = c;
    r.mul_en  = 1'b1;
    r.mul_a   = a;
    r.mul_b   = b;
    r.mul_dst = dst;
    return r;
  endfunction

  always_comb begin
    cmd           = '0;
    cmd.use_saved = use_saved_q;
    state_d       = state_q;
    op_d          = op_q;
    func_d        = func_q;
    last_d        = last_q;
    saved_op_d    = saved_op_q;
    eff_d         = eff_q;
    use_saved_d   = use_saved_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          cmd.err_clr = (in_op_i == OP_LOAD) || (in_op_i == OP_REPEAT);
          op_d        = in_op_i;
          func_d      = in_func_i;
          last_d      = in_last_i;
          use_saved_d = 1'b0;
          if ((in_op_i <= OP_REPEAT) &&
              ((in_func_i == FN_SQUARE) || (in_func_i == FN_RECIP))) begin
            state_d = ST_F_M0;
          end else begin
            state_d = ST_OP;
          end
        end
      end
      ST_F_M0: begin
        cmd     = mul(cmd, SRC_C, SRC_C, 2'd0);
        state_d = ST_F_M1;
      end
      ST_F_M1: begin
        cmd     = mul(cmd, SRC_D, SRC_D, 2'd1);
        state_d = (func_q == FN_SQUARE) ? ST_F_M2 : ST_F_NORM;
      end
      ST_F_M2: begin
        cmd     = mul(cmd, SRC_C, SRC_D, 2'd2);
        state_d = ST_F_SQ;
      end
      ST_F_SQ: begin
        cmd.sq_wb = 1'b1;
        state_d   = ST_OP;
      end
      ST_F_NORM: begin
        cmd.norm_wb = 1'b1;
        state_d     = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (sts_i.norm_zero) begin
          cmd.recip_zero = 1'b1;
          cmd.err_set    = 1'b1;
          state_d        = ST_OP;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_num   = NUM_C;
          state_d       = ST_F_DX;
        end
      end
      ST_F_DX: begin
        if (!sts_i.div_busy) begin
          cmd.div_wb    = 1'b1;
          cmd.div_dst   = DST_X;
          cmd.div_start = 1'b1;
          cmd.div_num   = NUM_NEGY;
          state_d       = ST_F_DY;
        end
      end
      ST_F_DY: begin
        if (!sts_i.div_busy) begin
          cmd.div_wb  = 1'b1;
          cmd.div_dst = DST_Y;
          state_d     = ST_OP;
        end
      end
      ST_OP: begin
        state_d = ST_FIN;
        unique case (op_q)
          OP_LOAD: begin
            cmd.acc_load = 1'b1;
          end
          OP_REPEAT: begin
            cmd.acc_load = 1'b1;
            if ((func_q == FN_NONE) && (saved_op_q != SAVED_NONE)) begin
              eff_d       = saved_op_q;
              use_saved_d = 1'b1;
              state_d     = ST_APPLY;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            cmd.save    = 1'b1;
            saved_op_d  = op_q;
            eff_d       = op_q;
            use_saved_d = 1'b0;
            state_d     = ST_APPLY;
          end
          OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            saved_op_d    = SAVED_NONE;
          end
          default: ;
        endcase
      end
      ST_APPLY: begin
        unique case (eff_q)
          OP_ADD: begin
            cmd.acc_add = 1'b1;
            state_d     = ST_FIN;
          end
          OP_SUB: begin
            cmd.acc_sub = 1'b1;
            state_d     = ST_FIN;
          end
          OP_MUL:  state_d = ST_M_M0;
          OP_DIV:  state_d = ST_D_M0;
          default: state_d = ST_FIN;
        endcase
      end
      ST_M_M0: begin
        cmd     = mul(cmd, SRC_ACC_RE, SRC_C, 2'd0);
        state_d = ST_M_M1;
      end
      ST_M_M1: begin
        cmd     = mul(cmd, SRC_ACC_IM, SRC_D, 2'd1);
        state_d = ST_M_M2;
      end
      ST_M_M2: begin
        cmd     = mul(cmd, SRC_ACC_RE, SRC_D, 2'd2);
        state_d = ST_M_M3;
      end
      ST_M_M3: begin
        cmd     = mul(cmd, SRC_ACC_IM, SRC_C, 2'd3);
        state_d = ST_M_WB;
      end
      ST_M_WB: begin
        cmd.acc_mul_wb = 1'b1;
        state_d        = ST_FIN;
      end
      ST_D_M0: begin
        cmd     = mul(cmd, SRC_C, SRC_C, 2'd0);
        state_d = ST_D_M1;
      end
      ST_D_M1: begin
        cmd     = mul(cmd, SRC_D, SRC_D, 2'd1);
        state_d = ST_D_NORM;
      end
      ST_D_NORM: begin
        cmd.norm_wb = 1'b1;
        state_d     = ST_D_CHK;
      end
      ST_D_CHK: begin
        if (sts_i.norm_zero) begin
          cmd.err_set = 1'b1;
          state_d     = ST_FIN;
        end else begin
          cmd     = mul(cmd, SRC_ACC_RE, SRC_C, 2'd0);
          state_d = ST_D_P1;
        end
      end
      ST_D_P1: begin
        cmd     = mul(cmd, SRC_ACC_IM, SRC_D, 2'd1);
        state_d = ST_D_P2;
      end
      ST_D_P2: begin
        cmd     = mul(cmd, SRC_ACC_IM, SRC_C, 2'd2);
        state_d = ST_D_P3;
      end
      ST_D_P3: begin
        cmd     = mul(cmd, SRC_ACC_RE, SRC_D, 2'd3);
        state_d = ST_D_NUM;
      end
      ST_D_NUM: begin
        cmd.num_wb = 1'b1;
        state_d    = ST_D_DS;
      end
      ST_D_DS: begin
        cmd.div_start = 1'b1;
        cmd.div_num   = NUM_P0;
        state_d       = ST_D_WR;
      end
      ST_D_WR: begin
        if (!sts_i.div_busy) begin
          cmd.div_wb    = 1'b1;
          cmd.div_dst   = DST_ACC_RE;
          cmd.div_start = 1'b1;
          cmd.div_num   = NUM_P1;
          state_d       = ST_D_WI;
        end
      end
      ST_D_WI: begin
        if (!sts_i.div_busy) begin
          cmd.div_wb  = 1'b1;
          cmd.div_dst = DST_ACC_IM;
          state_d     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_LOAD;
      func_q      <= FN_NONE;
      last_q      <= 1'b0;
      saved_op_q  <= SAVED_NONE;
      eff_q       <= SAVED_NONE;
      use_saved_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      func_q      <= func_d;
      last_q      <= last_d;
      saved_op_q  <= saved_op_d;
      eff_q       <= eff_d;
      use_saved_q <= use_saved_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // a new result never overwrites one the receiver has not taken
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  // the divider is only started when it is free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  // an accepted transaction always leaves idle for the operand or operator step
  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_F_M0 || state_q == ST_OP))
    else $error("accepted transaction not dispatched");

endmodule
